>>> hw/rtl/sfd_pkg.sv
// shared types and constants of the sensor frame deframer
package sfd_pkg;

   // frame layout
   localparam int unsigned FRAME_LEN     = 212;
   localparam int unsigned HEAD_LEN      = 18;
   localparam int unsigned DATA_START    = 20;
   localparam int unsigned READING_BYTES = 6;

   // field widths
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned POS_W    = 8;
   localparam int unsigned WIN_IDX_W = 5;
   localparam int unsigned CHAN_W   = 5;
   localparam int unsigned CCNT_W   = 6;
   localparam int unsigned PART_W   = 24;
   localparam int unsigned SCALED_W = 44;
   localparam int unsigned TYPE_W   = 16;
   localparam int unsigned SUB_W    = 3;
   localparam int unsigned RSP_DATA_W = 152;

   // constant bytes and values
   localparam logic [BYTE_W-1:0] HEADER_BYTE     = 8'hFF;
   localparam logic [TYPE_W-1:0] TYPE_WORD_RESET = 16'h0012;
   localparam logic [19:0]       MICRO_SCALE     = 20'd1000000;

   // one decoded reading with the running peak
   typedef struct packed {
      logic [SCALED_W-1:0] peak_value;
      logic [CHAN_W-1:0]   peak_channel;
      logic [SCALED_W-1:0] scaled_value;
      logic [PART_W-1:0]   micro_part;
      logic [PART_W-1:0]   whole_part;
      logic [CHAN_W-1:0]   channel;
      logic                frame_end;
   } result_type;

endpackage

>>> hw/rtl/sensor_frame_deframer.sv
// top level of the sensor frame deframer
//
//  channel   dir   handshake             payload
//  req       in    req_tvalid/tready     tdata[7:0] rx_byte
//  rsp       out   rsp_tvalid/tready     tdata: readings and peak, tlast frame_end
//  csr       in    csr_wr_en             csr_wr_data[15:0] frame_type_word
//
// one byte is taken per cycle while req_tready is high; its effect on the
// hunt window, the frame position and the reading registers settles in that
// same cycle, and a reading is pushed into the output stages on its sixth byte.
// the whole-part multiply by one million runs on the third byte of a reading,
// so the sixth byte sees only an add and the peak compare.
// reset is synchronous and clears the hunt, the frame state and both
// output stages; req_tready drops only while both output stages are full.
module sensor_frame_deframer
   import sfd_pkg::*;
#(
   parameter int unsigned SENSOR_COUNT = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BYTE_W-1:0]     req_tdata,    // [7:0] rx_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,    // [4:0] channel, [28:5] whole_part,
                                               // [52:29] micro_part, [96:53] scaled_value,
                                               // [101:97] peak_channel,
                                               // [145:102] peak_value, [151:146] zero
   output logic                  rsp_tlast,    // frame_end
   input  logic                  csr_wr_en,
   input  logic [TYPE_W-1:0]     csr_wr_data
);

   // state
   logic [BYTE_W-1:0]   win_ff [HEAD_LEN];
   logic [BYTE_W-1:0]   win_in [HEAD_LEN];
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic                in_frame_ff, in_frame_in;
   logic [39:0]         shift_ff, shift_in;
   logic [SCALED_W-1:0] prod_ff, prod_in;
   logic [SUB_W-1:0]    sub_ff, sub_in;
   logic [CCNT_W-1:0]   chan_ff, chan_in;
   logic [SCALED_W-1:0] best_value_ff, best_value_in;
   logic [CHAN_W-1:0]   best_chan_ff, best_chan_in;
   logic [TYPE_W-1:0]   type_ff;

   // datapath
   logic [BYTE_W-1:0]   rx_byte;
   logic                accept;
   logic [BYTE_W-1:0]   win_wr [HEAD_LEN];
   logic [BYTE_W-1:0]   win_sh [HEAD_LEN];
   logic                pair_found;
   logic [WIN_IDX_W-1:0] pair_at;
   logic [WIN_IDX_W:0]  src_idx;
   logic [SCALED_W-1:0] scaled;
   logic                push;
   result_type          push_data;
   result_type          rsp_data;
   logic                buf_room;

   assign rx_byte    = req_tdata;
   assign req_tready = buf_room;
   assign accept     = req_tvalid && req_tready;

   // window with the incoming byte written at the current position
   always_comb begin
      for (int i = 0; i < HEAD_LEN; i++) begin
         win_wr[i] = win_ff[i];
      end
      if (pos_ff < POS_W'(HEAD_LEN)) begin
         win_wr[pos_ff[WIN_IDX_W-1:0]] = rx_byte;
      end
   end

   // earliest header pair from the second byte on
   always_comb begin
      pair_found = 1'b0;
      pair_at    = '0;
      for (int h = HEAD_LEN - 2; h >= 1; h--) begin
         if (win_wr[h] == HEADER_BYTE && win_wr[h+1] == HEADER_BYTE) begin
            pair_found = 1'b1;
            pair_at    = WIN_IDX_W'(h);
         end
      end
   end

   // window shifted so that the found pair leads
   always_comb begin
      src_idx = '0;
      for (int i = 0; i < HEAD_LEN; i++) begin
         src_idx = (WIN_IDX_W+1)'(i) + {1'b0, pair_at};
         if (src_idx < (WIN_IDX_W+1)'(HEAD_LEN)) begin
            win_sh[i] = win_wr[src_idx[WIN_IDX_W-1:0]];
         end else begin
            win_sh[i] = 8'h00;
         end
      end
   end

   // reading value from the registered product and the fractional bytes
   assign scaled = prod_ff + SCALED_W'({shift_ff[15:0], rx_byte});

   // next state for one accepted byte
   always_comb begin
      win_in        = win_ff;
      pos_in        = pos_ff;
      in_frame_in   = in_frame_ff;
      shift_in      = shift_ff;
      prod_in       = prod_ff;
      sub_in        = sub_ff;
      chan_in       = chan_ff;
      best_value_in = best_value_ff;
      best_chan_in  = best_chan_ff;
      push          = 1'b0;
      push_data     = '0;
      if (accept) begin
         if (!in_frame_ff) begin
            if (pos_ff < POS_W'(2) && rx_byte != HEADER_BYTE) begin
               pos_in = '0;
            end else if (pos_ff == POS_W'(HEAD_LEN - 1)) begin
               // header complete: check the type word or resync
               win_in = win_wr;
               if ({win_wr[16], win_wr[17]} == type_ff) begin
                  in_frame_in   = 1'b1;
                  pos_in        = POS_W'(HEAD_LEN);
                  sub_in        = '0;
                  chan_in       = '0;
                  best_value_in = '0;
                  best_chan_in  = '0;
               end else if (pair_found) begin
                  win_in = win_sh;
                  pos_in = POS_W'(HEAD_LEN) - POS_W'(pair_at);
               end else if (win_wr[HEAD_LEN-1] == HEADER_BYTE) begin
                  win_in[0] = HEADER_BYTE;
                  pos_in    = POS_W'(1);
               end else begin
                  pos_in = '0;
               end
            end else begin
               win_in = win_wr;
               pos_in = pos_ff + POS_W'(1);
            end
         end else begin
            // reading bytes
            if (pos_ff >= POS_W'(DATA_START)) begin
               shift_in = {shift_ff[31:0], rx_byte};
               if (sub_ff == SUB_W'(2)) begin
                  prod_in = SCALED_W'({shift_ff[15:0], rx_byte}) * SCALED_W'(MICRO_SCALE);
               end
               if (sub_ff == SUB_W'(READING_BYTES - 1)) begin
                  sub_in  = '0;
                  chan_in = chan_ff + CCNT_W'(1);
                  if (chan_ff < CCNT_W'(SENSOR_COUNT)) begin
                     push = 1'b1;
                     if (scaled > best_value_ff) begin
                        best_value_in = scaled;
                        best_chan_in  = chan_ff[CHAN_W-1:0];
                     end
                     push_data.channel      = chan_ff[CHAN_W-1:0];
                     push_data.whole_part   = shift_ff[39:16];
                     push_data.micro_part   = {shift_ff[15:0], rx_byte};
                     push_data.scaled_value = scaled;
                     push_data.frame_end    = (chan_ff == CCNT_W'(SENSOR_COUNT - 1));
                     push_data.peak_channel = best_chan_in;
                     push_data.peak_value   = best_value_in;
                  end
               end else begin
                  sub_in = sub_ff + SUB_W'(1);
               end
            end
            // frame position
            if (pos_ff == POS_W'(FRAME_LEN - 1)) begin
               in_frame_in = 1'b0;
               pos_in      = '0;
            end else begin
               pos_in = pos_ff + POS_W'(1);
            end
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         in_frame_ff   <= 1'b0;
         sub_ff        <= '0;
         chan_ff       <= '0;
         best_value_ff <= '0;
         best_chan_ff  <= '0;
         type_ff       <= TYPE_WORD_RESET;
         for (int i = 0; i < HEAD_LEN; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         pos_ff        <= pos_in;
         in_frame_ff   <= in_frame_in;
         sub_ff        <= sub_in;
         chan_ff       <= chan_in;
         best_value_ff <= best_value_in;
         best_chan_ff  <= best_chan_in;
         win_ff        <= win_in;
         if (csr_wr_en) begin
            type_ff <= csr_wr_data;
         end
      end
   end

   // reading assembly registers
   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      prod_ff  <= prod_in;
   end

   // output stages
   sfd_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .has_room  (buf_room),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_data),
      .out_ready (rsp_tready)
   );

   // result word packing
   assign rsp_tdata = {6'b000000, rsp_data.peak_value, rsp_data.peak_channel,
                       rsp_data.scaled_value, rsp_data.micro_part,
                       rsp_data.whole_part, rsp_data.channel};
   assign rsp_tlast = rsp_data.frame_end;

endmodule

>>> hw/rtl/sfd_rsp_buf.sv
// two-entry output register with skid stage for result words
module sfd_rsp_buf
   import sfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       has_room,
   output logic       out_valid,
   output result_type out_data,
   input  logic       out_ready
);

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_data_ff, out_data_in;
   result_type skid_data_ff, skid_data_in;
   logic       pop;

   assign pop       = out_valid_ff && out_ready;
   assign has_room  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   // refill the output register from the skid stage first, then from a new word
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = push;
            skid_data_in  = push_data;
         end else begin
            out_valid_in = push;
            out_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

>>> hw/rtl/sfd_checker.sv
// port checker of the sensor frame deframer and its bind
module sfd_checker
   import sfd_pkg::*;
#(
   parameter int unsigned SENSOR_COUNT = 32
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   // the peak never lies below the reading that it includes
   a_peak_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[145:102] >= rsp_tdata[96:53])
      else $error("peak value below current reading");

   // the peak channel is one already seen in this frame
   a_peak_chan: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[101:97] <= rsp_tdata[4:0])
      else $error("peak channel ahead of current channel");

   // the frame end marks the last sensor only
   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tlast == (rsp_tdata[4:0] == CHAN_W'(SENSOR_COUNT - 1)))
      else $error("frame end on wrong channel");

   // both output stages are empty after reset
   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("not ready after reset");

endmodule

bind sensor_frame_deframer sfd_checker #(.SENSOR_COUNT(SENSOR_COUNT)) u_sfd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

>>> test/sensor_frame_deframer_tb.sv
// testbench of the sensor frame deframer: table-driven frames, random streams, live predictor
`timescale 1ns / 1ps

module sensor_frame_deframer_tb;
   import sfd_pkg::*;

   localparam int unsigned SENSORS        = 32;
   localparam int          HALF_PERIOD    = 4;
   localparam int          RESET_CYCLES   = 7;
   localparam int          HOLDOFF        = 4;
   localparam int          END_WAIT       = 16;
   localparam int          WATCHDOG_LIMIT = 4000;
   localparam int          PHASE_BYTES    = 200;
   localparam logic [SCALED_W-1:0] FULL_SCALE = 44'd16777231777215;

   typedef enum logic [2:0] {
      SEG_FRAME, SEG_BAD_TYPE, SEG_BAD_PAIR, SEG_BAD_TRAIL, SEG_NOISE, SEG_CONFIG
   } seg_kind_type;

   typedef enum logic [2:0] {
      FILL_ZERO, FILL_ONES, FILL_RAMP, FILL_DESCEND, FILL_TIE, FILL_MICRO_EDGE, FILL_RANDOM
   } fill_kind_type;

   // one stimulus row; reading fields hold the typed-in result where typed is set
   typedef struct packed {
      seg_kind_type        kind;
      fill_kind_type       fill;
      logic [TYPE_W-1:0]   arg;
      logic                typed;
      logic [PART_W-1:0]   whole;
      logic [PART_W-1:0]   micro;
      logic [SCALED_W-1:0] scaled;
      logic [SCALED_W-1:0] peak;
   } stim_row_type;

   localparam int DIRECTED_COUNT = 7;
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{SEG_NOISE,     FILL_RANDOM,     16'd6,    1'b0, 24'd0, 24'd0, 44'd0, 44'd0},
      '{SEG_FRAME,     FILL_ONES,       16'd0,    1'b1, 24'hFFFFFF, 24'hFFFFFF,
        FULL_SCALE, FULL_SCALE},
      '{SEG_CONFIG,    FILL_RANDOM,     16'hFFFF, 1'b0, 24'd0, 24'd0, 44'd0, 44'd0},
      '{SEG_FRAME,     FILL_ZERO,       16'd0,    1'b1, 24'd0, 24'd0, 44'd0, 44'd0},
      '{SEG_BAD_TYPE,  FILL_RANDOM,     16'd0,    1'b0, 24'd0, 24'd0, 44'd0, 44'd0},
      '{SEG_BAD_TRAIL, FILL_RANDOM,     16'd0,    1'b0, 24'd0, 24'd0, 44'd0, 44'd0},
      '{SEG_NOISE,     FILL_RANDOM,     16'd20,   1'b0, 24'd0, 24'd0, 44'd0, 44'd0}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_wr_en = 1'b0;
   logic [TYPE_W-1:0]     csr_wr_data = '0;

   // predictor state
   logic [BYTE_W-1:0]   hunt_win [HEAD_LEN] = '{default: '0};
   int unsigned         frame_pos = 0;
   bit                  frame_locked = 1'b0;
   logic [47:0]         reading_acc = '0;
   logic [SCALED_W-1:0] peak_val = '0;
   logic [CHAN_W-1:0]   peak_ch = '0;
   logic [TYPE_W-1:0]   type_word = TYPE_WORD_RESET;

   result_type   pending_readings [$];
   result_type   seen, want;
   stim_row_type typed_row;
   bit           typed_on = 1'b0;
   int unsigned  sent_count = 0;
   int           error_count = 0;
   int           idle_cycles = 0;
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;
   logic [TYPE_W-1:0] phase_word;

   sensor_frame_deframer #(.SENSOR_COUNT(SENSORS)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // clock
   always begin
      clock = 1'b0;
      #HALF_PERIOD;
      clock = 1'b1;
      #HALF_PERIOD;
   end

   // advance the deframer by one byte, return 1 when a reading completes
   function automatic bit decode_byte(input logic [BYTE_W-1:0] rx, output result_type rd);
      int unsigned k;
      int unsigned ch;
      logic [63:0] wide;
      logic [PART_W-1:0] whole;
      logic [PART_W-1:0] micro;
      bit found;
      rd = '0;
      if (!frame_locked) begin
         if (frame_pos >= HEAD_LEN) frame_pos = 0;
         if (frame_pos < 2 && rx != HEADER_BYTE) begin
            frame_pos = 0;
            return 1'b0;
         end
         hunt_win[frame_pos] = rx;
         frame_pos++;
         if (frame_pos == HEAD_LEN) begin
            if ({hunt_win[16], hunt_win[17]} == type_word) begin
               frame_locked = 1'b1;
               reading_acc = '0;
               peak_val = '0;
               peak_ch = '0;
            end else begin
               // drop the first byte and realign on the earliest header pair
               found = 1'b0;
               for (int h = 1; h + 1 < HEAD_LEN; h++) begin
                  if (!found && hunt_win[h] == HEADER_BYTE && hunt_win[h+1] == HEADER_BYTE) begin
                     for (int j = 0; j < HEAD_LEN - h; j++) hunt_win[j] = hunt_win[j+h];
                     frame_pos = HEAD_LEN - h;
                     found = 1'b1;
                  end
               end
               if (!found) begin
                  if (hunt_win[HEAD_LEN-1] == HEADER_BYTE) begin
                     hunt_win[0] = HEADER_BYTE;
                     frame_pos = 1;
                  end else begin
                     frame_pos = 0;
                  end
               end
            end
         end
         return 1'b0;
      end
      // inside a frame
      found = 1'b0;
      if (frame_pos >= DATA_START && frame_pos < FRAME_LEN) begin
         k = frame_pos - DATA_START;
         ch = k / READING_BYTES;
         reading_acc = {reading_acc[39:0], rx};
         if (k % READING_BYTES == READING_BYTES - 1 && ch < SENSORS) begin
            whole = reading_acc[47:24];
            micro = reading_acc[23:0];
            wide = whole * 64'd1000000 + micro;
            if (wide[SCALED_W-1:0] > peak_val) begin
               peak_val = wide[SCALED_W-1:0];
               peak_ch = ch[CHAN_W-1:0];
            end
            rd.channel = ch[CHAN_W-1:0];
            rd.whole_part = whole;
            rd.micro_part = micro;
            rd.scaled_value = wide[SCALED_W-1:0];
            rd.frame_end = (ch == SENSORS - 1);
            rd.peak_channel = peak_ch;
            rd.peak_value = peak_val;
            found = 1'b1;
         end
      end
      frame_pos++;
      if (frame_pos >= FRAME_LEN) begin
         frame_locked = 1'b0;
         frame_pos = 0;
      end
      return found;
   endfunction

   // one 24-bit part, biased toward the edges
   function automatic logic [PART_W-1:0] random_part();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return 24'd999999;
         3: return 24'd1000000;
         default: return 24'($urandom);
      endcase
   endfunction

   // whole and micro parts of one reading for a given fill pattern
   function automatic logic [47:0] reading_for(input fill_kind_type fill, input int unsigned ch);
      logic [PART_W-1:0] whole;
      logic [PART_W-1:0] micro;
      case (fill)
         FILL_ZERO: begin
            whole = '0;
            micro = '0;
         end
         FILL_ONES: begin
            whole = '1;
            micro = '1;
         end
         FILL_RAMP: begin
            whole = 24'(ch);
            micro = 24'(ch * 31250);
         end
         FILL_DESCEND: begin
            whole = 24'(SENSORS - 1 - ch);
            micro = '0;
         end
         FILL_TIE: begin
            whole = 24'd7;
            micro = 24'd500000;
         end
         FILL_MICRO_EDGE: begin
            whole = 24'($urandom_range(0, 3));
            case (ch % 4)
               0: micro = 24'd999999;
               1: micro = 24'd1000000;
               2: micro = '1;
               default: micro = '0;
            endcase
         end
         default: begin
            whole = random_part();
            micro = random_part();
         end
      endcase
      return {whole, micro};
   endfunction

   function automatic void check_field(input string name, input logic [63:0] exp_val,
                                       input logic [63:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, exp_val, act_val);
         error_count++;
      end
   endfunction

   // offer one word, wait for it to be taken, then predict
   task automatic send_byte(input logic [BYTE_W-1:0] rx);
      result_type r;
      bit got;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rx;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
      got = decode_byte(rx, r);
      if (got) begin
         if (typed_on) begin
            r.whole_part   = typed_row.whole;
            r.micro_part   = typed_row.micro;
            r.scaled_value = typed_row.scaled;
            r.peak_value   = typed_row.peak;
            r.peak_channel = '0;
         end
         pending_readings.push_back(r);
      end
   endtask

   // hold the sender until every reading is out, then let the pipe drain
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (HOLDOFF) @(posedge clock);
   endtask

   task automatic write_type_word(input logic [TYPE_W-1:0] value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      type_word = value;
   endtask

   // full 212-byte frame with the given type word
   task automatic send_frame(input fill_kind_type fill, input logic [TYPE_W-1:0] tw);
      logic [47:0] reading;
      logic [BYTE_W-1:0] rx;
      int unsigned k;
      reading = '0;
      for (int unsigned i = 0; i < FRAME_LEN; i++) begin
         if (i < 2) rx = HEADER_BYTE;
         else if (i == 16) rx = tw[15:8];
         else if (i == 17) rx = tw[7:0];
         else if (i < DATA_START) begin
            if (fill == FILL_ZERO) rx = 8'h00;
            else if (fill == FILL_ONES) rx = 8'hFF;
            else rx = 8'($urandom);
         end else begin
            k = i - DATA_START;
            if (k % READING_BYTES == 0) reading = reading_for(fill, k / READING_BYTES);
            rx = reading[47 - 8 * (k % READING_BYTES) -: 8];
         end
         send_byte(rx);
      end
   endtask

   task automatic run_segment(input seg_kind_type kind, input fill_kind_type fill,
                              input logic [TYPE_W-1:0] arg);
      logic [TYPE_W-1:0] bad_word;
      logic [BYTE_W-1:0] hi;
      case (kind)
         SEG_FRAME: send_frame(fill, type_word);
         // header with a wrong type word, random body
         SEG_BAD_TYPE: begin
            bad_word = type_word ^ 16'($urandom_range(1, 65535));
            send_byte(HEADER_BYTE);
            send_byte(HEADER_BYTE);
            repeat (14) send_byte(8'($urandom));
            send_byte(bad_word[15:8]);
            send_byte(bad_word[7:0]);
         end
         // false start whose window holds the real header four bytes in
         SEG_BAD_PAIR: begin
            send_byte(HEADER_BYTE);
            send_byte(HEADER_BYTE);
            send_byte(8'($urandom_range(0, 254)));
            send_byte(8'($urandom_range(0, 254)));
            send_frame(fill, type_word);
         end
         // mismatch with no pair but a trailing header byte
         SEG_BAD_TRAIL: begin
            send_byte(HEADER_BYTE);
            send_byte(HEADER_BYTE);
            repeat (14) send_byte(8'($urandom_range(0, 254)));
            hi = 8'($urandom_range(0, 254));
            if ({hi, HEADER_BYTE} == type_word) hi = (hi == 8'h00) ? 8'h01 : 8'h00;
            send_byte(hi);
            send_byte(HEADER_BYTE);
         end
         SEG_NOISE: begin
            repeat (arg) send_byte(($urandom_range(3) == 0) ? HEADER_BYTE
                                                           : 8'($urandom_range(0, 254)));
         end
         SEG_CONFIG: write_type_word(arg);
         default: ;
      endcase
   endtask

   // receiver stalls
   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= recv_stall_pct);

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.channel      = rsp_tdata[4:0];
         seen.whole_part   = rsp_tdata[28:5];
         seen.micro_part   = rsp_tdata[52:29];
         seen.scaled_value = rsp_tdata[96:53];
         seen.peak_channel = rsp_tdata[101:97];
         seen.peak_value   = rsp_tdata[145:102];
         seen.frame_end    = rsp_tlast;
         if (pending_readings.size() == 0) begin
            $display("%0t: unexpected word, expected none actual channel %0d scaled %0h",
                     $time, seen.channel, seen.scaled_value);
            error_count++;
         end else begin
            want = pending_readings.pop_front();
            check_field("channel", want.channel, seen.channel);
            check_field("whole_part", want.whole_part, seen.whole_part);
            check_field("micro_part", want.micro_part, seen.micro_part);
            check_field("scaled_value", want.scaled_value, seen.scaled_value);
            check_field("frame_end", want.frame_end, seen.frame_end);
            check_field("peak_channel", want.peak_channel, seen.peak_channel);
            check_field("peak_value", want.peak_value, seen.peak_value);
         end
      end
   end

   // watchdog on cycles with no word moving on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // stimulus
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed rows, no idling
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         typed_row = DIRECTED_ROWS[i];
         typed_on  = DIRECTED_ROWS[i].typed;
         run_segment(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].fill, DIRECTED_ROWS[i].arg);
      end
      typed_on = 1'b0;

      // random streams, one type word and idle pattern per phase
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
               phase_word = 16'hFFFF;
            end
            1: begin
               send_idle_pct = 75;
               recv_stall_pct = 0;
               phase_word = 16'h0000;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 75;
               phase_word = 16'($urandom);
            end
            default: begin
               send_idle_pct = 30;
               recv_stall_pct = 30;
               phase_word = TYPE_WORD_RESET;
            end
         endcase
         write_type_word(phase_word);
         sent_count = 0;
         while (sent_count < PHASE_BYTES) begin
            case ($urandom_range(9))
               0, 1, 2, 3, 4, 5: run_segment(SEG_FRAME, ($urandom_range(99) < 70) ? FILL_RANDOM
                                             : fill_kind_type'($urandom_range(0, 5)), '0);
               6: run_segment(SEG_BAD_TYPE, FILL_RANDOM, '0);
               7: run_segment(SEG_BAD_PAIR, FILL_RANDOM, '0);
               8: run_segment(SEG_BAD_TRAIL, FILL_RANDOM, '0);
               default: run_segment(SEG_NOISE, FILL_RANDOM, 16'($urandom_range(1, 30)));
            endcase
            if ($urandom_range(99) < 15) settle();
         end
      end

      // drain and finish
      req_tvalid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (END_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/sfd_pkg.sv
hw/rtl/sfd_rsp_buf.sv
hw/rtl/sensor_frame_deframer.sv
hw/rtl/sfd_checker.sv
test/sensor_frame_deframer_tb.sv
